### sv/eai_pkg.sv
// Shared constants, types and helpers for the elementwise integer ALU.
package eai_pkg;

    // Element width and external field width
    localparam int Width   = 32;
    localparam int FieldW  = 32;
    localparam int OpW     = 3;

    // Operation codes
    localparam logic [OpW-1:0] OP_ADD = 3'd0;
    localparam logic [OpW-1:0] OP_SUB = 3'd1;
    localparam logic [OpW-1:0] OP_MUL = 3'd2;
    localparam logic [OpW-1:0] OP_DIV = 3'd3;
    localparam logic [OpW-1:0] OP_MOD = 3'd4;

    // Configuration register indexes
    localparam logic CFG_UNSIGNED_ELEMENTS = 1'b0;
    localparam logic CFG_TRUNCATING_MOD    = 1'b1;

    typedef logic [Width-1:0] word_t;

    // Sideband that rides along the divider chain
    typedef struct packed {
        logic [OpW-1:0] op;
        logic           lhs_neg;
        logic           rhs_neg;
        logic           zero_div;
        logic           is_unsigned;
        word_t          rhs;
        word_t          alu;
    } side_t;

    // One stage of the restoring divider chain
    typedef struct packed {
        word_t rem;
        word_t aq;
        word_t dvs;
        side_t side;
    } div_stage_t;

    // Two's complement negate at element width
    function automatic word_t negate(input word_t v);
        negate = ~v + word_t'(1);
    endfunction

endpackage

### sv/eai_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per cycle while en is high.
module eai_div_cell import eai_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  div_stage_t in_stage,
    output logic       out_valid,
    output div_stage_t out_stage
);

    logic               out_valid_reg;
    div_stage_t         out_stage_reg;
    div_stage_t         out_stage_next;
    logic [Width:0]     shifted;
    logic [Width:0]     trial;
    logic               fits;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        shifted = {in_stage.rem, in_stage.aq[Width-1]};
        trial   = shifted - {1'b0, in_stage.dvs};
        fits    = ~trial[Width];
        out_stage_next      = in_stage;
        out_stage_next.rem  = fits ? trial[Width-1:0] : shifted[Width-1:0];
        out_stage_next.aq   = {in_stage.aq[Width-2:0], fits};
    end

    // Advance valid with the pipeline enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= in_valid;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            out_stage_reg <= out_stage_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_stage = out_stage_reg;

    // Partial remainder stays below a nonzero divisor
    a_rem_below_dvs: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_stage_reg.dvs != '0) |-> (out_stage_reg.rem < out_stage_reg.dvs))
        else $error("divider cell remainder not below divisor");

endmodule

### sv/elementwise_integer_alu_core.sv
// Top level of the elementwise integer ALU: input stage, divider chain, result stage.
// Registered path from input transfer to result valid: the input stage, the Width divider cells, then the result stage.
// One item per cycle when not stalled; the divider is a chain of Width cells, one bit each.
// The whole pipeline advances together; it stalls only while a result waits on m_ready.
// Reset (aresetn low, synchronous): clears all valid bits and both config registers.
// No clearing pass; the block accepts items in the first cycle after reset.
module elementwise_integer_alu_core import eai_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic              cfg_wdata,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OpW-1:0]    s_operation,
    input  logic [FieldW-1:0] s_lhs_value,
    input  logic [FieldW-1:0] s_rhs_value,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [FieldW-1:0] m_result_value,
    output logic              m_zero_divisor
);

    logic              unsigned_elements_reg;
    logic              truncating_mod_reg;
    logic              en;
    logic              stage_valid [Width+1];
    div_stage_t        stage       [Width+1];
    logic              pre_valid_reg;
    div_stage_t        pre_stage_reg;
    div_stage_t        pre_stage_next;
    word_t             a;
    word_t             b;
    word_t             prod;
    logic              m_valid_reg;
    logic [FieldW-1:0] m_result_value_reg;
    logic              m_zero_divisor_reg;
    logic [OpW-1:0]    m_op_reg;
    word_t             res_next;
    word_t             rem_signed;
    side_t             post_side;

    // Hold the pipeline while a finished result waits
    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unsigned_elements_reg <= 1'b0;
            truncating_mod_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_UNSIGNED_ELEMENTS: unsigned_elements_reg <= cfg_wdata;
                CFG_TRUNCATING_MOD:    truncating_mod_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input stage: simple ops, signs and magnitudes for the divider
    always_comb begin
        a    = s_lhs_value[Width-1:0];
        b    = s_rhs_value[Width-1:0];
        prod = a * b;
        pre_stage_next                  = '0;
        pre_stage_next.side.op          = s_operation;
        pre_stage_next.side.is_unsigned = unsigned_elements_reg;
        pre_stage_next.side.lhs_neg     = ~unsigned_elements_reg & a[Width-1];
        pre_stage_next.side.rhs_neg     = ~unsigned_elements_reg & b[Width-1];
        pre_stage_next.side.zero_div    = (b == '0);
        pre_stage_next.side.rhs         = b;
        case (s_operation)
            OP_ADD:  pre_stage_next.side.alu = a + b;
            OP_SUB:  pre_stage_next.side.alu = a - b;
            OP_MUL:  pre_stage_next.side.alu = prod;
            default: pre_stage_next.side.alu = '0;
        endcase
        pre_stage_next.rem = '0;
        pre_stage_next.aq  = pre_stage_next.side.lhs_neg ? negate(a) : a;
        pre_stage_next.dvs = pre_stage_next.side.rhs_neg ? negate(b) : b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (en) begin
            pre_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_stage_reg <= pre_stage_next;
        end
    end

    assign stage_valid[0] = pre_valid_reg;
    assign stage[0]       = pre_stage_reg;

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < Width; i++) begin : g_cell
        eai_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_stage  (stage[i]),
            .out_valid (stage_valid[i+1]),
            .out_stage (stage[i+1])
        );
    end

    // Result stage: sign fix-up and, unless truncating modulo is configured, floor modulo correction
    always_comb begin
        post_side  = stage[Width].side;
        rem_signed = post_side.lhs_neg ? negate(stage[Width].rem) : stage[Width].rem;
        if (!post_side.is_unsigned && !truncating_mod_reg && stage[Width].rem != '0
                && post_side.lhs_neg != post_side.rhs_neg) begin
            rem_signed = rem_signed + post_side.rhs;
        end
        case (post_side.op)
            OP_DIV: begin
                if (post_side.zero_div) begin
                    res_next = '0;
                end else begin
                    res_next = (post_side.lhs_neg != post_side.rhs_neg)
                             ? negate(stage[Width].aq) : stage[Width].aq;
                end
            end
            OP_MOD: begin
                res_next = post_side.zero_div ? '0 : rem_signed;
            end
            default: res_next = post_side.alu;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= stage_valid[Width];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_result_value_reg <= FieldW'(res_next);
            m_zero_divisor_reg <= post_side.zero_div
                               & (post_side.op == OP_DIV || post_side.op == OP_MOD);
            m_op_reg           <= post_side.op;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_zero_divisor = m_zero_divisor_reg;

    // A zero divisor on divide or modulo always gives a zero result
    a_zero_div_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zero_divisor_reg) |-> (m_result_value_reg == '0))
        else $error("zero divisor with nonzero result");

    // Only divide and modulo raise the zero divisor flag
    a_zero_div_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_zero_divisor_reg) |-> (m_op_reg == OP_DIV || m_op_reg == OP_MOD))
        else $error("zero divisor flag on a non-dividing operation");

    // An input transfer enters the first stage
    a_transfer_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> pre_valid_reg)
        else $error("input transfer lost at the input stage");

endmodule
